// ===== rtl/core/rbd_pkg.sv =====
// Shared constants and types for the Rabin byte decryptor.
// Holds field widths, register indexes, reset values and the sequencer states.
// No dependencies.
package rbd_pkg;

  localparam int PRIME_BITS_DEF = 20;
  localparam int WORD_W         = 40;
  localparam int BYTE_W         = 8;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PRIME_P  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_Q  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B = 2'd2;

  localparam int RESET_P = 3;
  localparam int RESET_Q = 7;

  localparam int MAX_PLAIN = 255;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_RB,
    ST_RBB,
    ST_R4C,
    ST_DADD,
    ST_PCHK,
    ST_PR,
    ST_PSQ,
    ST_PB,
    ST_EINIT,
    ST_ECHK,
    ST_DIV,
    ST_EX,
    ST_EXS,
    ST_EYS,
    ST_F1,
    ST_F2,
    ST_BN,
    ST_K0,
    ST_KA,
    ST_KB,
    ST_KR,
    ST_KT,
    ST_KM,
    ST_DONE,
    ST_MUL
  } state_t;

endpackage

// ===== rtl/core/rabin_byte_decrypt.sv =====
// Rabin decryption of one ciphertext word into one plaintext byte.
// Depends on rbd_pkg for widths, register indexes and the state type.
//
// Usage:
//   Configuration: cfg_write with cfg_index 0, 1 or 2 loads prime_p, prime_q or
//   offset_b from cfg_data. Write only while the block is idle.
//   Input channel: a ciphertext transaction moves on cipher_valid with
//   cipher_stall low. cipher_stall is high while a word is being worked on.
//   Output channel: plain_byte and root_found are held with plain_valid until
//   a cycle with plain_stall low. A new word is taken while a result waits; the
//   next result is held inside until the output register is free.
// Arithmetic: all modular products run through one bit-serial modular
//   multiplier, one doubling or one add per cycle. A word takes two
//   exponentiations of about PRIME_BITS squarings and products each, plus an
//   extended-Euclid loop whose steps each run a serial divider and two products.
// Throughput: one word at a time.
// Reset: rst loads prime_p=3, prime_q=7, offset_b=0 and empties the output
//   register. If either prime is below 3 the result is 0 with root_found 0.
module rabin_byte_decrypt #(
  parameter int PRIME_BITS = rbd_pkg::PRIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbd_pkg::WORD_W-1:0]    cfg_data,
  input  logic                          cipher_valid,
  output logic                          cipher_stall,
  input  logic [rbd_pkg::WORD_W-1:0]    cipher_word,
  output logic                          plain_valid,
  input  logic                          plain_stall,
  output logic [rbd_pkg::BYTE_W-1:0]    plain_byte,
  output logic                          root_found
);
  import rbd_pkg::*;

  localparam int PB    = PRIME_BITS;
  localparam int NW    = 2 * PRIME_BITS;
  localparam int CNT_W = $clog2(WORD_W + 1);
  localparam int DCW   = $clog2(PB + 1);

  // Configuration registers.
  logic [PB-1:0]     prime_p;
  logic [PB-1:0]     prime_q;
  logic [WORD_W-1:0] offset_b;

  // Sequencer.
  state_t state, state_next;
  state_t ret;

  // Shared serial multiplier.
  logic [NW-1:0]     acc;
  logic [NW-1:0]     mul_a;
  logic [NW-1:0]     mul_m;
  logic [WORD_W-1:0] mb;
  logic [CNT_W-1:0]  cnt;
  logic              phase;

  // Datapath registers.
  logic [WORD_W-1:0] cword;
  logic [NW-1:0]     n;
  logic              pi;
  logic [NW-1:0]     tmp;
  logic [PB-1:0]     rr;
  logic [PB-1:0]     base;
  logic [PB-1:0]     ex;
  logic [PB-1:0]     mp;
  logic [PB-1:0]     mq;
  logic [PB-1:0]     d0;
  logic [PB-1:0]     d1;
  logic [PB-1:0]     xa0;
  logic [PB-1:0]     xa1;
  logic [PB-1:0]     xa2;
  logic [PB-1:0]     ya0;
  logic [PB-1:0]     ya1;
  logic [PB:0]       rem;
  logic [PB-1:0]     dq;
  logic [DCW-1:0]    dcnt;
  logic [NW-1:0]     f1;
  logic [NW-1:0]     f2;
  logic [NW-1:0]     bn;
  logic [1:0]        k;
  logic [BYTE_W-1:0] res_byte;
  logic              res_found;

  // Combinational helpers.
  logic [PB-1:0] cur_mod;
  logic [NW-1:0] cur_mod_w;
  logic [NW-1:0] four_mod;
  logic [PB:0]   div_r2;
  logic          div_ge;
  logic [PB-1:0] sp;
  logic [PB-1:0] sq;
  logic [NW-1:0] m_cand;
  logic [PB:0]   p_inc;
  logic          mul_done;
  logic          out_load;

  function automatic logic [NW-1:0] add_mod(input logic [NW-1:0] a, input logic [NW-1:0] b,
                                            input logic [NW-1:0] m);
    logic [NW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[NW-1:0];
  endfunction

  function automatic logic [NW-1:0] sub_mod(input logic [NW-1:0] a, input logic [NW-1:0] b,
                                            input logic [NW-1:0] m);
    logic [NW-1:0] s;
    if (a >= b) begin
      s = a - b;
    end else begin
      s = a + (m - b);
    end
    return s;
  endfunction

  function automatic logic [WORD_W-1:0] scan_pb(input logic [PB-1:0] v);
    return {v, {(WORD_W - PB){1'b0}}};
  endfunction

  always_comb begin
    cur_mod   = pi ? prime_q : prime_p;
    cur_mod_w = NW'(cur_mod);
    p_inc     = {1'b0, cur_mod} + {{PB{1'b0}}, 1'b1};
    if (cur_mod == PB'(3)) begin
      four_mod = NW'(1);
    end else if (cur_mod == PB'(4)) begin
      four_mod = '0;
    end else begin
      four_mod = NW'(4);
    end
    div_r2 = {rem[PB-1:0], dq[PB-1]};
    div_ge = (div_r2 >= {1'b0, d1});
    sp = k[0] ? ((mp == '0) ? '0 : prime_p - mp) : mp;
    sq = k[1] ? ((mq == '0) ? '0 : prime_q - mq) : mq;
    // Halving modulo n: an odd value gets n added before the shift.
    m_cand   = (tmp >> 1) + (tmp[0] ? ((n >> 1) + NW'(n[0])) : '0);
    mul_done = phase && (cnt == CNT_W'(1));
  end

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      prime_p  <= PB'(RESET_P);
      prime_q  <= PB'(RESET_Q);
      offset_b <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PRIME_P:  prime_p  <= cfg_data[PB-1:0];
        REG_PRIME_Q:  prime_q  <= cfg_data[PB-1:0];
        REG_OFFSET_B: offset_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (cipher_valid) state_next = ST_START;
      ST_START: state_next = (prime_p < PB'(3) || prime_q < PB'(3)) ? ST_DONE : ST_RB;
      ST_RB, ST_RBB, ST_R4C: state_next = ST_MUL;
      ST_DADD:  state_next = ST_PCHK;
      ST_PCHK: begin
        if (ex == '0) begin
          state_next = pi ? ST_EINIT : ST_RB;
        end else if (ex[0]) begin
          state_next = ST_MUL;
        end else begin
          state_next = ST_PSQ;
        end
      end
      ST_PR:    state_next = ST_PSQ;
      ST_PSQ:   state_next = ST_MUL;
      ST_PB:    state_next = ST_PCHK;
      ST_EINIT: state_next = ST_ECHK;
      ST_ECHK:  state_next = (d1 <= PB'(1)) ? ST_F1 : ST_DIV;
      ST_DIV:   if (dcnt == DCW'(1)) state_next = ST_EX;
      ST_EX, ST_EXS, ST_F1, ST_F2, ST_BN, ST_KA, ST_KB: state_next = ST_MUL;
      ST_EYS:   state_next = ST_ECHK;
      ST_K0:    state_next = ST_KA;
      ST_KR:    state_next = ST_KT;
      ST_KT:    state_next = ST_KM;
      ST_KM: begin
        if (m_cand <= NW'(MAX_PLAIN) || k == 2'd3) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_KA;
        end
      end
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      ST_MUL:   if (mul_done) state_next = ret;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    cipher_stall = (state != ST_IDLE);
    out_load     = (state == ST_DONE) && (!plain_valid || !plain_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (cipher_valid) begin
          cword <= cipher_word;
        end
      end
      ST_START: begin
        n         <= NW'(prime_p) * NW'(prime_q);
        pi        <= 1'b0;
        res_byte  <= '0;
        res_found <= 1'b0;
      end
      ST_RB: begin
        mul_a <= NW'(1);
        mb    <= offset_b;
        cnt   <= CNT_W'(WORD_W);
        mul_m <= cur_mod_w;
        acc   <= '0;
        phase <= 1'b0;
        ret   <= ST_RBB;
      end
      ST_RBB: begin
        mul_a <= acc;
        mb    <= offset_b;
        cnt   <= CNT_W'(WORD_W);
        acc   <= '0;
        phase <= 1'b0;
        ret   <= ST_R4C;
      end
      ST_R4C: begin
        tmp   <= acc;
        mul_a <= four_mod;
        mb    <= cword;
        cnt   <= CNT_W'(WORD_W);
        acc   <= '0;
        phase <= 1'b0;
        ret   <= ST_DADD;
      end
      ST_DADD: begin
        base <= PB'(add_mod(tmp, acc, cur_mod_w));
        rr   <= PB'(1);
        ex   <= PB'(p_inc[PB:2]);
      end
      ST_PCHK: begin
        if (ex == '0) begin
          if (pi) begin
            mq <= rr;
          end else begin
            mp <= rr;
          end
          pi <= 1'b1;
        end else if (ex[0]) begin
          mul_a <= NW'(rr);
          mb    <= scan_pb(base);
          cnt   <= CNT_W'(PB);
          mul_m <= cur_mod_w;
          acc   <= '0;
          phase <= 1'b0;
          ret   <= ST_PR;
        end
      end
      ST_PR: begin
        rr <= acc[PB-1:0];
      end
      ST_PSQ: begin
        mul_a <= NW'(base);
        mb    <= scan_pb(base);
        cnt   <= CNT_W'(PB);
        mul_m <= cur_mod_w;
        acc   <= '0;
        phase <= 1'b0;
        ret   <= ST_PB;
      end
      ST_PB: begin
        base <= acc[PB-1:0];
        ex   <= ex >> 1;
      end
      ST_EINIT: begin
        d0  <= prime_p;
        d1  <= prime_q;
        xa0 <= PB'(1);
        xa1 <= '0;
        ya0 <= '0;
        ya1 <= PB'(1);
      end
      ST_ECHK: begin
        dq   <= d0;
        rem  <= '0;
        dcnt <= DCW'(PB);
      end
      ST_DIV: begin
        // One restoring division step: quotient bits shift in behind the dividend.
        if (div_ge) begin
          rem <= div_r2 - {1'b0, d1};
        end else begin
          rem <= div_r2;
        end
        dq   <= {dq[PB-2:0], div_ge};
        dcnt <= dcnt - DCW'(1);
      end
      ST_EX: begin
        mul_a <= NW'(xa1);
        mb    <= scan_pb(dq);
        cnt   <= CNT_W'(PB);
        mul_m <= NW'(prime_q);
        acc   <= '0;
        phase <= 1'b0;
        ret   <= ST_EXS;
      end
      ST_EXS: begin
        xa2   <= PB'(sub_mod(NW'(xa0), acc, NW'(prime_q)));
        mul_a <= NW'(ya1);
        mb    <= scan_pb(dq);
        cnt   <= CNT_W'(PB);
        mul_m <= NW'(prime_p);
        acc   <= '0;
        phase <= 1'b0;
        ret   <= ST_EYS;
      end
      ST_EYS: begin
        d0  <= d1;
        d1  <= rem[PB-1:0];
        xa0 <= xa1;
        xa1 <= xa2;
        ya0 <= ya1;
        ya1 <= PB'(sub_mod(NW'(ya0), acc, NW'(prime_p)));
      end
      ST_F1: begin
        mul_a <= NW'(prime_q);
        mb    <= scan_pb(ya1);
        cnt   <= CNT_W'(PB);
        mul_m <= n;
        acc   <= '0;
        phase <= 1'b0;
        ret   <= ST_F2;
      end
      ST_F2: begin
        f1    <= acc;
        mul_a <= NW'(prime_p);
        mb    <= scan_pb(xa1);
        cnt   <= CNT_W'(PB);
        acc   <= '0;
        phase <= 1'b0;
        ret   <= ST_BN;
      end
      ST_BN: begin
        f2    <= acc;
        mul_a <= NW'(1);
        mb    <= offset_b;
        cnt   <= CNT_W'(WORD_W);
        acc   <= '0;
        phase <= 1'b0;
        ret   <= ST_K0;
      end
      ST_K0: begin
        bn <= acc;
        k  <= 2'd0;
      end
      ST_KA: begin
        mul_a <= f1;
        mb    <= scan_pb(sp);
        cnt   <= CNT_W'(PB);
        acc   <= '0;
        phase <= 1'b0;
        ret   <= ST_KB;
      end
      ST_KB: begin
        tmp   <= acc;
        mul_a <= f2;
        mb    <= scan_pb(sq);
        cnt   <= CNT_W'(PB);
        acc   <= '0;
        phase <= 1'b0;
        ret   <= ST_KR;
      end
      ST_KR: begin
        tmp <= add_mod(tmp, acc, n);
      end
      ST_KT: begin
        tmp <= sub_mod(tmp, bn, n);
      end
      ST_KM: begin
        if (m_cand <= NW'(MAX_PLAIN)) begin
          res_byte  <= m_cand[BYTE_W-1:0];
          res_found <= 1'b1;
        end
        k <= k + 2'd1;
      end
      ST_MUL: begin
        // Left-to-right double and add, one modular add per cycle.
        if (!phase) begin
          acc <= add_mod(acc, acc, mul_m);
        end else begin
          if (mb[WORD_W-1]) begin
            acc <= add_mod(acc, mul_a, mul_m);
          end
          mb  <= mb << 1;
          cnt <= cnt - CNT_W'(1);
        end
        phase <= !phase;
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      plain_valid <= 1'b0;
    end else if (out_load) begin
      plain_valid <= 1'b1;
    end else if (!plain_stall) begin
      plain_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      plain_byte <= res_byte;
      root_found <= res_found;
    end
  end

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> cnt != '0)
    else $error("multiplier running with an empty bit count");

  a_mul_reduced: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> acc < mul_m)
    else $error("multiplier accumulator not reduced");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    cipher_valid && !cipher_stall |=> state == ST_START)
    else $error("accepted transaction did not start the sequence");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    plain_valid && !root_found |-> plain_byte == '0)
    else $error("nonzero byte without a root");

endmodule

// ===== dv/tb_rabin_byte_decrypt.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rabin_byte_decrypt: encrypted bytes and noise words
// under several prime and offset settings, checked against an in-bench predictor.
// Depends on rbd_pkg and the rabin_byte_decrypt RTL.
module tb_rabin_byte_decrypt;
  import rbd_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] plain;
    logic              found;
  } plain_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;
  logic                 cipher_valid = 1'b0;
  logic                 cipher_stall;
  logic [WORD_W-1:0]    cipher_word = '0;
  logic                 plain_valid;
  logic                 plain_stall = 1'b0;
  logic [BYTE_W-1:0]    plain_byte;
  logic                 root_found;

  // Shadow copy of the key registers.
  longint unsigned key_p = RESET_P;
  longint unsigned key_q = RESET_Q;
  longint unsigned key_b = 0;

  logic [WORD_W-1:0] cipher_q[$];
  plain_t            plain_exp_q[$];
  int                mismatch_cnt = 0;
  int                burst_left = 0;
  int                gap_left = 0;
  int                hold_left = 0;
  bit                hold_req = 1'b0;
  int                stall_mode = 0;
  int                mode_left = 0;

  always #4 clk = ~clk;

  rabin_byte_decrypt u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cipher_valid(cipher_valid), .cipher_stall(cipher_stall),
    .cipher_word(cipher_word), .plain_valid(plain_valid), .plain_stall(plain_stall),
    .plain_byte(plain_byte), .root_found(root_found)
  );

  function automatic longint unsigned mul_mod_n(longint unsigned a, longint unsigned b,
                                                longint unsigned m);
    logic [127:0] prod;
    prod = 128'(a % m) * 128'(b % m);
    return 64'(prod % 128'(m));
  endfunction

  function automatic longint unsigned pow_mod_n(longint unsigned base, longint unsigned e,
                                                longint unsigned m);
    longint unsigned r;
    r = 1 % m;
    base = base % m;
    while (e != 0) begin
      if (e[0]) r = mul_mod_n(r, base, m);
      base = mul_mod_n(base, base, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic longint unsigned wrap_signed(longint v, longint unsigned m);
    longint unsigned r;
    if (v >= 0) return longint'(v) % m;
    r = longint'(-v) % m;
    return (r == 0) ? 0 : m - r;
  endfunction

  function automatic plain_t decrypt_byte(logic [WORD_W-1:0] c);
    plain_t          res;
    longint unsigned n, dp, dq, mp, mq, f1, f2, bn, sp, sq, r, t, m;
    longint          d0, d1, d2, x0, x1, x2, y0, y1, y2, qt;
    res = '0;
    if (key_p < 3 || key_q < 3) return res;
    n  = key_p * key_q;
    dp = (mul_mod_n(key_b, key_b, key_p) + mul_mod_n(4, c, key_p)) % key_p;
    dq = (mul_mod_n(key_b, key_b, key_q) + mul_mod_n(4, c, key_q)) % key_q;
    mp = pow_mod_n(dp, (key_p + 1) / 4, key_p);
    mq = pow_mod_n(dq, (key_q + 1) / 4, key_q);
    d0 = key_p; d1 = key_q;
    x0 = 1; x1 = 0; y0 = 0; y1 = 1;
    while (d1 > 1) begin
      qt = d0 / d1; d2 = d0 % d1;
      x2 = x0 - qt * x1; y2 = y0 - qt * y1;
      d0 = d1; d1 = d2; x0 = x1; x1 = x2; y0 = y1; y1 = y2;
    end
    f1 = mul_mod_n(key_q, wrap_signed(y1, key_p), n);
    f2 = mul_mod_n(key_p, wrap_signed(x1, key_q), n);
    bn = key_b % n;
    // Roots in sign order (+,+), (-,+), (+,-), (-,-).
    for (int k = 0; k < 4; k++) begin
      sp = (k & 1) ? ((mp == 0) ? 0 : key_p - mp) : mp;
      sq = (k & 2) ? ((mq == 0) ? 0 : key_q - mq) : mq;
      r  = (mul_mod_n(sp, f1, n) + mul_mod_n(sq, f2, n)) % n;
      t  = (r >= bn) ? r - bn : r + (n - bn);
      m  = (t >> 1) + (t[0] ? (n >> 1) + (n & 1) : 0);
      if (m <= MAX_PLAIN) begin
        res.plain = m[BYTE_W-1:0];
        res.found = 1'b1;
        return res;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic add_word(logic [WORD_W-1:0] w);
    cipher_q = {cipher_q, w};
  endtask

  task automatic add_expected(plain_t e);
    plain_exp_q = {plain_exp_q, e};
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      cipher_valid <= 1'b0;
    end else if (!cipher_valid || !cipher_stall) begin
      if (cipher_valid) add_expected(decrypt_byte(cipher_word));
      if (gap_left > 0) begin
        gap_left--;
        cipher_valid <= 1'b0;
      end else if (cipher_q.size() > 0) begin
        cipher_valid <= 1'b1;
        cipher_word  <= cipher_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 6);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        cipher_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern changes now and then; one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      plain_stall <= 1'b0;
    end else if (hold_req && hold_left == 0) begin
      hold_req  = 1'b0;
      hold_left = 20000;
      plain_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      plain_stall <= (hold_left != 0);
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(100, 3000);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: plain_stall <= 1'b0;
        1: plain_stall <= 1'($urandom_range(0, 1));
        default: plain_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Result checker.
  always @(posedge clk) begin
    plain_t exp_res;
    if (!rst && plain_valid && !plain_stall) begin
      if (plain_exp_q.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0d with none expected", plain_byte,
                                  root_found));
      end else begin
        exp_res = plain_exp_q.pop_front();
        if (plain_byte !== exp_res.plain)
          report_mismatch($sformatf("plain_byte %0d, expected %0d", plain_byte,
                                    exp_res.plain));
        if (root_found !== exp_res.found)
          report_mismatch($sformatf("root_found %0b, expected %0b", root_found,
                                    exp_res.found));
      end
    end
  end

  task automatic write_key(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_PRIME_P) key_p = val[PRIME_BITS_DEF-1:0];
    else if (idx == REG_PRIME_Q) key_q = val[PRIME_BITS_DEF-1:0];
    else if (idx == REG_OFFSET_B) key_b = val;
  endtask

  task automatic drain();
    @(negedge clk);
    while (cipher_q.size() != 0 || cipher_valid || plain_exp_q.size() != 0)
      @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  // Mostly valid encryptions, usually of a byte, the rest noise words.
  task automatic queue_phase(int cnt);
    longint unsigned n, m;
    logic [127:0]    prod;
    n = key_p * key_q;
    for (int i = 0; i < cnt; i++) begin
      if (n == 0 || $urandom_range(0, 4) == 0) begin
        add_word(40'({$urandom, $urandom}));
      end else begin
        m = ($urandom_range(0, 5) == 0) ? {$urandom, $urandom} % n : $urandom_range(0, 255);
        prod = 128'(m) * 128'((m + key_b % n) % n);
        add_word(40'(prod % 128'(n)));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // Reset key: n = 21, b = 0.
    add_word(40'd0);
    add_word(40'd1);
    add_word(40'd4);
    add_word(40'd16);
    add_word(40'd20);
    add_word(40'hFF_FFFF_FFFF);
    add_word(40'hAA_AAAA_AAAA);
    queue_phase(40);
    drain();
    // Largest primes below one million that are 3 mod 4, offset at its maximum.
    write_key(REG_PRIME_P, 40'd999983);
    write_key(REG_PRIME_Q, 40'd999979);
    write_key(REG_OFFSET_B, 40'hFF_FFFF_FFFF);
    queue_phase(50);
    hold_req = 1'b1;
    drain();
    // Composite all-ones prime field.
    write_key(REG_PRIME_P, 40'hF_FFFF);
    write_key(REG_PRIME_Q, 40'd3);
    write_key(REG_OFFSET_B, 40'd0);
    queue_phase(40);
    drain();
    // Degenerate modulus: no root can be found.
    write_key(REG_PRIME_P, 40'd0);
    write_key(REG_PRIME_Q, 40'd7);
    queue_phase(10);
    drain();
    write_key(REG_PRIME_P, 40'd11);
    write_key(REG_PRIME_Q, 40'd2);
    queue_phase(10);
    drain();
    // Even modulus.
    write_key(REG_PRIME_P, 40'd1000);
    write_key(REG_PRIME_Q, 40'd11);
    write_key(REG_OFFSET_B, 40'd5);
    queue_phase(40);
    drain();
    // Mid-size primes with a random offset.
    write_key(REG_PRIME_P, 40'd1019);
    write_key(REG_PRIME_Q, 40'd1031);
    write_key(REG_OFFSET_B, 40'($urandom_range(0, 1019 * 1031 - 1)));
    queue_phase(60);
    drain();
    write_key(REG_PRIME_P, 40'd7);
    write_key(REG_PRIME_Q, 40'd499979);
    write_key(REG_OFFSET_B, 40'd123456);
    queue_phase(50);
    drain();
    if (mismatch_cnt == 0) begin
      $display("tb_rabin_byte_decrypt: done, clean");
    end else begin
      $display("tb_rabin_byte_decrypt: done, errors");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("tb_rabin_byte_decrypt: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rbd_pkg.sv
rtl/core/rabin_byte_decrypt.sv
dv/tb_rabin_byte_decrypt.sv
